// ----- rtl/wrs_pkg.sv -----
// shared types, constants and register codes of the weighted 3x3 rgb smoothing block
`timescale 1ns / 1ps

package wrs_pkg;

  // geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int WID_W     = 11;
  localparam int HGT_W     = 12;

  // pixel and arithmetic widths
  localparam int PIX_W            = 24;
  localparam int CH_W             = 8;
  localparam int NUM_CH           = PIX_W / CH_W;
  localparam int WGT_W            = 12;
  localparam int WEIGHT_FRAC_BITS = 12;
  localparam int SUM_W            = CH_W + WGT_W + 4;
  localparam int NUM_TAPS         = 9;
  localparam int NUM_CELLS        = 2;

  localparam logic [WID_W-1:0] MIN_DIM_W = WID_W'(3);
  localparam logic [WID_W-1:0] MAX_DIM_W = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] MIN_DIM_H = HGT_W'(3);
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic [CH_W-1:0]  CH_MAX     = '1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_WEIGHT_CENTER = 3'd2,
    REG_WEIGHT_EDGE   = 3'd3,
    REG_WEIGHT_CORNER = 3'd4
  } cfg_reg_e;

  // reset values of the registers
  localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'(1024);
  localparam logic [HGT_W-1:0] RST_HEIGHT = HGT_W'(768);
  localparam logic [WGT_W-1:0] RST_CENTER = WGT_W'(2048);
  localparam logic [WGT_W-1:0] RST_EDGE   = WGT_W'(410);
  localparam logic [WGT_W-1:0] RST_CORNER = WGT_W'(102);

  // one column of the three-line window
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } wcol_t;

  // weights handed to the channel lanes
  typedef struct packed {
    logic [WGT_W-1:0] center;
    logic [WGT_W-1:0] side;
    logic [WGT_W-1:0] corner;
  } wgt_t;

endpackage

// ----- rtl/wrs_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module wrs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/wrs_cell.sv -----
// one window column cell: holds three pixels and passes them to its neighbor
`timescale 1ns / 1ps

module wrs_cell import wrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  wcol_t din_i,
  output wcol_t dout_o
);

  wcol_t col_q;

  // shift in the column from the previous cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= din_i;
    end
  end

  assign dout_o = col_q;

endmodule

// ----- rtl/wrs_chan.sv -----
// one color lane: tap sums, weight products, rounding and saturation
`timescale 1ns / 1ps

module wrs_chan import wrs_pkg::*; (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [NUM_TAPS-1:0][CH_W-1:0]  taps_i,
  input  wgt_t                           wgt_i,
  output logic [CH_W-1:0]                res_o
);

  localparam int GRP_W  = CH_W + 2;
  localparam int PC_W   = CH_W + WGT_W;
  localparam int PG_W   = GRP_W + WGT_W;
  localparam int SHR_W  = SUM_W - WEIGHT_FRAC_BITS;

  logic [CH_W-1:0]  ctr_q;
  logic [GRP_W-1:0] side_q, corn_q;
  logic [PC_W-1:0]  prod_c_q;
  logic [PG_W-1:0]  prod_s_q, prod_k_q;
  logic [SUM_W-1:0] total;
  logic [SHR_W-1:0] scaled;

  // group the taps: center, four sides, four corners
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctr_q  <= taps_i[4];
      side_q <= GRP_W'(taps_i[1]) + GRP_W'(taps_i[3]) + GRP_W'(taps_i[5]) + GRP_W'(taps_i[7]);
      corn_q <= GRP_W'(taps_i[0]) + GRP_W'(taps_i[2]) + GRP_W'(taps_i[6]) + GRP_W'(taps_i[8]);
    end
  end

  // weight products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_c_q <= PC_W'(ctr_q) * PC_W'(wgt_i.center);
      prod_s_q <= PG_W'(side_q) * PG_W'(wgt_i.side);
      prod_k_q <= PG_W'(corn_q) * PG_W'(wgt_i.corner);
    end
  end

  // round half up, drop fraction bits, clamp to the channel range
  always_comb begin
    total  = SUM_W'(prod_c_q) + SUM_W'(prod_s_q) + SUM_W'(prod_k_q) + ROUND_HALF;
    scaled = total[SUM_W-1:WEIGHT_FRAC_BITS];
    if (scaled > SHR_W'(CH_MAX)) begin
      res_o = CH_MAX;
    end else begin
      res_o = scaled[CH_W-1:0];
    end
  end

endmodule

// ----- rtl/weighted_3x3_rgb_smoothing.sv -----
// top level: line store, window cell chain, color lanes and stream ports
// result path: stage-1 register, lane tap-group and product registers, output register
// throughput: one pixel per cycle if not stalled; one line-store read and write per pixel
// a result word held by the receiver stalls the whole pipe, input included
// border pixels are consumed and give no result word
// reset: counters and window cleared, registers to defaults, line store not cleared
`timescale 1ns / 1ps

module weighted_3x3_rgb_smoothing import wrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,  // [23:0] pixel_in
  input  logic                  s_axis_tuser,  // [0] frame_start
  // result output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,  // [23:0] out_color, [33:24] out_col,
                                               // [45:34] out_row, [47:46] zero
  output logic                  m_axis_tlast,  // frame_done
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LS_W = 2 * PIX_W;

  // configuration registers
  logic [WID_W-1:0] cfg_width_q;
  logic [HGT_W-1:0] cfg_height_q;
  wgt_t             wgt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_WIDTH;
      cfg_height_q <= RST_HEIGHT;
      wgt_q.center <= RST_CENTER;
      wgt_q.side   <= RST_EDGE;
      wgt_q.corner <= RST_CORNER;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:   cfg_width_q  <= cfg_data_i[WID_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_height_q <= cfg_data_i[HGT_W-1:0];
        REG_WEIGHT_CENTER: wgt_q.center <= cfg_data_i[WGT_W-1:0];
        REG_WEIGHT_EDGE:   wgt_q.side   <= cfg_data_i[WGT_W-1:0];
        REG_WEIGHT_CORNER: wgt_q.corner <= cfg_data_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame geometry
  logic [WID_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;

  always_comb begin
    if (cfg_width_q < MIN_DIM_W) begin
      width_eff = MIN_DIM_W;
    end else if (cfg_width_q > MAX_DIM_W) begin
      width_eff = MAX_DIM_W;
    end else begin
      width_eff = cfg_width_q;
    end
    height_eff = (cfg_height_q < MIN_DIM_H) ? MIN_DIM_H : cfg_height_q;
  end

  // pipeline advance: everything moves when the output register is free or taken
  logic ov_q;
  logic en, accept;

  assign en            = !ov_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  // raster position of the incoming pixel
  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             interior, last_px;

  always_comb begin
    col_cur  = s_axis_tuser ? '0 : col_q;
    row_cur  = s_axis_tuser ? '0 : row_q;
    col_inc  = {1'b0, col_cur} + (COL_W+1)'(1);
    row_inc  = {1'b0, row_cur} + (ROW_W+1)'(1);
    interior = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
    last_px  = ({1'b0, col_cur} == (width_eff - WID_W'(1)))
            && (row_cur == (height_eff - HGT_W'(1)));
    col_d    = col_inc[COL_W-1:0];
    row_d    = row_cur;
    if (col_inc >= (COL_W+1)'(width_eff)) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: pixel waits for its line-store word
  logic             v1_q;
  logic [PIX_W-1:0] px1_q;
  logic [COL_W-1:0] col1_q;
  logic [ROW_W-1:0] row1_q;
  logic             int1_q, done1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q   <= s_axis_tdata;
      col1_q  <= col_cur;
      row1_q  <= row_cur;
      int1_q  <= interior;
      done1_q <= last_px;
    end
  end

  // line store: upper line in the low half, middle line in the high half
  logic            ls_we;
  logic [LS_W-1:0] ls_wdata, ls_rdata, ls_word;
  logic            fwd_hit_q;
  logic [LS_W-1:0] fwd_data_q;
  logic [PIX_W-1:0] line_up, line_mid;

  assign ls_we    = v1_q && en;
  assign ls_wdata = {px1_q, line_mid};

  wrs_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (col1_q),
    .wdata_i (ls_wdata),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ls_rdata)
  );

  // forward a word written at the same address in the read cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (accept) begin
      fwd_hit_q <= ls_we && (col1_q == col_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= ls_wdata;
    end
  end

  assign ls_word  = fwd_hit_q ? fwd_data_q : ls_rdata;
  assign line_up  = ls_word[PIX_W-1:0];
  assign line_mid = ls_word[LS_W-1:PIX_W];

  // window cell chain: entry column, then columns col-1 and col-2
  wcol_t chain [NUM_CELLS+1];
  logic  win_en;

  assign win_en        = v1_q && en;
  assign chain[0].top  = line_up;
  assign chain[0].mid  = line_mid;
  assign chain[0].bot  = px1_q;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    wrs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (win_en),
      .din_i  (chain[i]),
      .dout_o (chain[i+1])
    );
  end

  // 3x3 neighborhood, row-major, center at tap 4
  logic [NUM_TAPS-1:0][PIX_W-1:0] nb;

  always_comb begin
    nb[0] = chain[2].top;
    nb[1] = chain[1].top;
    nb[2] = chain[0].top;
    nb[3] = chain[2].mid;
    nb[4] = chain[1].mid;
    nb[5] = chain[0].mid;
    nb[6] = chain[2].bot;
    nb[7] = chain[1].bot;
    nb[8] = chain[0].bot;
  end

  // color lanes
  logic [PIX_W-1:0] color;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    logic [NUM_TAPS-1:0][CH_W-1:0] taps;

    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
      assign taps[k] = nb[k][c*CH_W +: CH_W];
    end

    wrs_chan u_chan (
      .clk_i  (clk_i),
      .en_i   (en),
      .taps_i (taps),
      .wgt_i  (wgt_q),
      .res_o  (color[c*CH_W +: CH_W])
    );
  end

  // stages 2 and 3: position tags follow the lane pipeline
  logic             v2_q, v3_q;
  logic [COL_W-1:0] col2_q, col3_q;
  logic [ROW_W-1:0] row2_q, row3_q;
  logic             done2_q, done3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q && int1_q;
      v3_q <= v2_q;
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col2_q  <= col1_q - COL_W'(1);
      row2_q  <= row1_q - ROW_W'(1);
      done2_q <= done1_q;
      col3_q  <= col2_q;
      row3_q  <= row2_q;
      done3_q <= done2_q;
    end
  end

  // output register
  logic [PIX_W-1:0] ocolor_q;
  logic [COL_W-1:0] ocol_q;
  logic [ROW_W-1:0] orow_q;
  logic             odone_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ocolor_q <= color;
      ocol_q   <= col3_q;
      orow_q   <= row3_q;
      odone_q  <= done3_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, orow_q, ocol_q, ocolor_q};
  assign m_axis_tlast  = odone_q;

endmodule
